// ===== sv/ipfb_pkg.sv =====
// Shared constants, register codes and queue item type for the palette frame blitter.
`default_nettype none

package ipfb_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int PAL_ADDR_BITS   = $clog2(PALETTE_ENTRIES);
   localparam int ADDRESS_BITS    = 32;
   localparam int INDEX_BITS      = 8;
   localparam int COLOR_BITS      = 24;
   localparam int GEOM_BITS       = 16;
   localparam int WIDE_BITS       = 2 * GEOM_BITS;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 16;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_LEFT         = 3'd0,
      CSR_FRAME_TOP          = 3'd1,
      CSR_FRAME_WIDTH        = 3'd2,
      CSR_FRAME_HEIGHT       = 3'd3,
      CSR_CANVAS_STRIDE      = 3'd4,
      CSR_TRANSPARENT_ENABLE = 3'd5,
      CSR_TRANSPARENT_INDEX  = 3'd6,
      CSR_OPAQUE_CANVAS      = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic                    load;
      logic [INDEX_BITS-1:0]   index;
      logic [COLOR_BITS-1:0]   color;
      logic [ADDRESS_BITS-1:0] address;
      logic                    write_color;
      logic                    write_alpha;
      logic                    last_pixel;
   } item_type;

endpackage

`default_nettype wire

// ===== sv/indexed_pixel_frame_blit.sv =====
// Top level of the indexed-colour frame blitter: front end, item queue, back end, result queue.
//
// Usage:
//  - Request side is a queue input: an item is taken on a clock edge with req_push high
//    and req_full low. Mode 0 loads palette entry req_color_index with req_palette_color
//    and gives no result; mode 1 is the next frame pixel in raster order.
//  - Result side is a queue output: while rsp_empty is low the oldest result sits on the
//    rsp_ ports and leaves on an edge with rsp_pop high.
//  - Registers are written through csr_write/csr_index/csr_wdata with no wait; write them
//    only while the block is drained. req_full stays high for the cycle after any write
//    while the frame origin (one 16x16 multiply) and row step settle.
//  - A pixel goes through the item queue, the registered palette read and the result queue.
//  - Throughput: one item per cycle while req_full stays low, set by the single palette
//    memory port (one write or one registered read each cycle) and the one-step address walk.
//  - When the receiver stalls, results gather in a four-entry result queue, then items
//    back up in a four-entry queue between the front and back ends, then req_full rises.
//  - Reset (synchronous, active high) empties both queues, loads register reset values
//    and restarts the frame at its origin; palette contents are undefined until loaded.
`default_nettype none

module indexed_pixel_frame_blit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire logic                                req_mode,
   input  wire logic [ipfb_pkg::INDEX_BITS-1:0]     req_color_index,
   input  wire logic [ipfb_pkg::COLOR_BITS-1:0]     req_palette_color,
   output logic                                     rsp_empty,
   input  wire logic                                rsp_pop,
   output logic [ipfb_pkg::ADDRESS_BITS-1:0]        rsp_canvas_address,
   output logic                                     rsp_write_color,
   output logic                                     rsp_write_alpha,
   output logic [ipfb_pkg::COLOR_BITS-1:0]          rsp_color,
   output logic                                     rsp_last_pixel,
   input  wire logic                                csr_write,
   input  wire logic [ipfb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [ipfb_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import ipfb_pkg::*;

   // Front end to item queue.
   logic                    front_push;
   item_type                front_item;
   logic                    mid_full;

   // Item queue to back end.
   logic                    mid_empty;
   logic                    mid_pop;
   item_type                mid_item;
   logic [QUEUE_PTR_BITS:0] mid_level;

   // Back end to result queue.
   logic                    out_push;
   item_type                out_item;
   logic                    out_full;
   logic [QUEUE_PTR_BITS:0] out_level;
   item_type                rsp_item;

   logic                    unused_flags;

   // Classify items, walk the raster and hold the registers.
   ipfb_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_mode          (req_mode),
      .req_color_index   (req_color_index),
      .req_palette_color (req_palette_color),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .queue_full        (mid_full),
      .item_push         (front_push),
      .item              (front_item)
   );

   // Decouple the front end from the palette lookup.
   ipfb_queue u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_item (front_item),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_item  (mid_item),
      .empty     (mid_empty),
      .level     (mid_level)
   );

   // Load the palette and look up pixel colours.
   ipfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_item  (mid_item),
      .mid_pop   (mid_pop),
      .out_level (out_level),
      .out_push  (out_push),
      .out_item  (out_item)
   );

   // Hold finished results until the receiver takes them.
   ipfb_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_item (out_item),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_item  (rsp_item),
      .empty     (rsp_empty),
      .level     (out_level)
   );

   // The back end reserves room before it pushes, so the result queue's full flag and
   // the item queue's fill level go unread.
   assign unused_flags = out_full | (|mid_level);

   assign rsp_canvas_address = rsp_item.address;
   assign rsp_write_color    = rsp_item.write_color;
   assign rsp_write_alpha    = rsp_item.write_alpha;
   assign rsp_color          = rsp_item.color;
   assign rsp_last_pixel     = rsp_item.last_pixel;

endmodule

`default_nettype wire

// ===== sv/ipfb_queue.sv =====
// Small first-in first-out queue of blitter items.
`default_nettype none

module ipfb_queue (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            push,
   input  wire ipfb_pkg::item_type              push_item,
   output logic                                 full,
   input  wire logic                            pop,
   output ipfb_pkg::item_type                   pop_item,
   output logic                                 empty,
   output logic [ipfb_pkg::QUEUE_PTR_BITS:0]    level
);
   import ipfb_pkg::*;

   item_type                  store_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic                      do_push, do_pop;

   assign full     = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign level    = count_ff;
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_item = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== sv/ipfb_front.sv =====
// Front end: registers, item classification and raster address generation.
`default_nettype none

module ipfb_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire logic                                req_mode,
   input  wire logic [ipfb_pkg::INDEX_BITS-1:0]     req_color_index,
   input  wire logic [ipfb_pkg::COLOR_BITS-1:0]     req_palette_color,
   input  wire logic                                csr_write,
   input  wire logic [ipfb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [ipfb_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  wire logic                                queue_full,
   output logic                                     item_push,
   output ipfb_pkg::item_type                       item
);
   import ipfb_pkg::*;

   logic [GEOM_BITS-1:0]    left_ff, top_ff, width_ff, height_ff, stride_ff;
   logic                    trans_en_ff;
   logic [INDEX_BITS-1:0]   trans_idx_ff;
   logic                    opaque_ff;

   logic [ADDRESS_BITS-1:0] origin_ff, origin_in;
   logic [ADDRESS_BITS-1:0] step_ff, step_in;
   logic                    settle_ff;
   logic                    start_ff;
   logic [GEOM_BITS-1:0]    column_ff, row_ff;
   logic [ADDRESS_BITS-1:0] next_addr_ff;

   logic [GEOM_BITS-1:0]    width_eff, height_eff;
   logic [WIDE_BITS-1:0]    product;
   logic [ADDRESS_BITS-1:0] pixel_addr;
   logic [GEOM_BITS:0]      column_plus, row_plus;
   logic                    row_end, last, accept, pixel, geom_write;
   logic                    write_color;

   // Zero width or height behaves as one.
   assign width_eff  = (width_ff  == '0) ? GEOM_BITS'(1) : width_ff;
   assign height_eff = (height_ff == '0) ? GEOM_BITS'(1) : height_ff;

   assign product   = WIDE_BITS'(top_ff) * WIDE_BITS'(stride_ff);
   assign origin_in = ADDRESS_BITS'(product + WIDE_BITS'(left_ff));
   assign step_in   = ADDRESS_BITS'(WIDE_BITS'(stride_ff) - WIDE_BITS'(width_eff)
                                    + WIDE_BITS'(1));

   // Hold off items in the cycle after a write so origin and step settle.
   assign req_full = queue_full | settle_ff;
   assign accept   = req_push & ~req_full;
   assign pixel    = accept & req_mode;

   assign pixel_addr  = start_ff ? origin_ff : next_addr_ff;
   assign column_plus = {1'b0, column_ff} + 1'b1;
   assign row_plus    = {1'b0, row_ff} + 1'b1;
   assign row_end     = (column_plus >= {1'b0, width_eff});
   assign last        = row_end & (row_plus >= {1'b0, height_eff});

   assign write_color = ~(trans_en_ff & (req_color_index == trans_idx_ff));

   assign geom_write = csr_write & (csr_index <= CSR_CANVAS_STRIDE);

   always_comb begin
      item.load        = ~req_mode;
      item.index       = req_color_index;
      item.color       = req_palette_color;
      item.address     = pixel_addr;
      item.write_color = write_color;
      item.write_alpha = write_color & ~opaque_ff;
      item.last_pixel  = last;
   end
   assign item_push = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         top_ff       <= '0;
         width_ff     <= GEOM_BITS'(1);
         height_ff    <= GEOM_BITS'(1);
         stride_ff    <= GEOM_BITS'(1);
         trans_en_ff  <= 1'b0;
         trans_idx_ff <= '0;
         opaque_ff    <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_LEFT:         left_ff      <= csr_wdata[GEOM_BITS-1:0];
            CSR_FRAME_TOP:          top_ff       <= csr_wdata[GEOM_BITS-1:0];
            CSR_FRAME_WIDTH:        width_ff     <= csr_wdata[GEOM_BITS-1:0];
            CSR_FRAME_HEIGHT:       height_ff    <= csr_wdata[GEOM_BITS-1:0];
            CSR_CANVAS_STRIDE:      stride_ff    <= csr_wdata[GEOM_BITS-1:0];
            CSR_TRANSPARENT_ENABLE: trans_en_ff  <= csr_wdata[0];
            CSR_TRANSPARENT_INDEX:  trans_idx_ff <= csr_wdata[INDEX_BITS-1:0];
            CSR_OPAQUE_CANVAS:      opaque_ff    <= csr_wdata[0];
            default:                opaque_ff    <= opaque_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= '0;
         step_ff   <= ADDRESS_BITS'(1);
         settle_ff <= 1'b0;
      end else begin
         origin_ff <= origin_in;
         step_ff   <= step_in;
         settle_ff <= csr_write;
      end
   end

   // Raster walk: restart on a geometry write or after the last pixel.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= 1'b1;
         column_ff    <= '0;
         row_ff       <= '0;
         next_addr_ff <= '0;
      end else if (geom_write) begin
         start_ff  <= 1'b1;
         column_ff <= '0;
         row_ff    <= '0;
      end else if (pixel) begin
         if (last) begin
            start_ff  <= 1'b1;
            column_ff <= '0;
            row_ff    <= '0;
         end else if (row_end) begin
            start_ff     <= 1'b0;
            column_ff    <= '0;
            row_ff       <= row_plus[GEOM_BITS-1:0];
            next_addr_ff <= pixel_addr + step_ff;
         end else begin
            start_ff     <= 1'b0;
            column_ff    <= column_plus[GEOM_BITS-1:0];
            next_addr_ff <= pixel_addr + 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/ipfb_back.sv =====
// Back end: palette memory, colour lookup and hand-off to the result queue.
`default_nettype none

module ipfb_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             mid_empty,
   input  wire ipfb_pkg::item_type               mid_item,
   output logic                                  mid_pop,
   input  wire logic [ipfb_pkg::QUEUE_PTR_BITS:0] out_level,
   output logic                                  out_push,
   output ipfb_pkg::item_type                    out_item
);
   import ipfb_pkg::*;

   logic [COLOR_BITS-1:0]    palette_mem [PALETTE_ENTRIES];
   logic [COLOR_BITS-1:0]    rd_data_ff;
   logic                     stage_valid_ff;
   item_type                 stage_item_ff;
   logic                     stage_range_ff;

   logic [PAL_ADDR_BITS-1:0] pal_addr;
   logic                     in_range;
   logic [QUEUE_PTR_BITS+1:0] committed;
   logic                     room;

   assign pal_addr = mid_item.index[PAL_ADDR_BITS-1:0];
   assign in_range = ({1'b0, mid_item.index} < (INDEX_BITS+1)'(PALETTE_ENTRIES));

   // Count the stage item against the result queue so a pushed result always fits.
   assign committed = {1'b0, out_level} + (QUEUE_PTR_BITS+2)'(stage_valid_ff);
   assign room      = (committed < (QUEUE_PTR_BITS+2)'(QUEUE_DEPTH));
   assign mid_pop   = ~mid_empty & room;

   always_ff @(posedge clock) begin
      if (mid_pop && mid_item.load && in_range) begin
         palette_mem[pal_addr] <= mid_item.color;
      end
      if (mid_pop && !mid_item.load) begin
         rd_data_ff <= palette_mem[pal_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= mid_pop & ~mid_item.load;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_pop) begin
         stage_item_ff  <= mid_item;
         stage_range_ff <= in_range;
      end
   end

   always_comb begin
      out_item       = stage_item_ff;
      out_item.load  = 1'b0;
      out_item.color = (stage_item_ff.write_color && stage_range_ff) ? rd_data_ff : '0;
   end
   assign out_push = stage_valid_ff;

endmodule

`default_nettype wire
